[rtl/core/bcsp_pkg.sv]
// shared types, constants and helpers of the block cipher stream padder
package bcsp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned BSIZE_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned LFSR_W    = 16;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 7'd16;
  localparam logic [LFSR_W-1:0]  LFSR_RESET  = 16'hACE1;
  localparam logic [BYTE_W-1:0]  ISO_MARK    = 8'h80;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 3'd0,
    MODE_PKCS7    = 3'd1,
    MODE_ISO7816  = 3'd2,
    MODE_ISO10126 = 3'd3,
    MODE_ANSI923  = 3'd4,
    MODE_ZERO     = 3'd5
  } pad_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PADDING_MODE = 1'b0,
    CFG_BLOCK_SIZE   = 1'b1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic load_msg;
    logic load_pad;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pad_on;
    logic pad_final;
    logic out_free;
  } dp_sts_t;

  // eight steps of the x^16+x^14+x^13+x^11+1 fibonacci lfsr
  function automatic logic [LFSR_W-1:0] lfsr_step8(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    logic              fb;
    r = s;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ r[2] ^ r[3] ^ r[5];
      r  = {fb, r[LFSR_W-1:1]};
    end
    return r;
  endfunction

endpackage

[rtl/core/bcsp_if.sv]
// valid/ready channel interfaces for message input and padded output
interface bcsp_in_if;
  logic                       valid;
  logic                       ready;
  logic [bcsp_pkg::BYTE_W-1:0] data_byte;
  logic                       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface bcsp_out_if;
  logic                       valid;
  logic                       ready;
  logic [bcsp_pkg::BYTE_W-1:0] out_byte;
  logic                       is_pad;
  logic                       end_of_message;

  modport source (output valid, output out_byte, output is_pad, output end_of_message,
                  input ready);
  modport sink   (input valid, input out_byte, input is_pad, input end_of_message,
                  output ready);
endinterface

[rtl/core/bcsp_datapath.sv]
// padder datapath: config registers, block position, pad counters, lfsr, output register
module bcsp_datapath #(
  parameter int unsigned MAX_BLOCK_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bcsp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [bcsp_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          is_last_i,
  input  bcsp_pkg::ctl_cmd_t            cmd_i,
  output bcsp_pkg::dp_sts_t             sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bcsp_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          is_pad_o,
  output logic                          end_of_message_o
);
  import bcsp_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_BLOCK_BYTES);
  localparam logic [BSIZE_W-1:0] BS_MAX = BSIZE_W'(MAX_BLOCK_BYTES);

  pad_mode_e            mode_q;
  logic [BSIZE_W-1:0]   bsize_q;
  logic [POS_W-1:0]     pos_q;
  logic [POS_W-1:0]     pad_len_q;
  logic [POS_W-1:0]     pad_idx_q;
  logic [LFSR_W-1:0]    lfsr_q;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic                 is_pad_q;
  logic                 eom_q;

  logic [BSIZE_W-1:0]   bs_eff;
  logic [BSIZE_W-1:0]   count_full;
  logic [BSIZE_W-1:0]   count;
  logic [BSIZE_W-1:0]   pad_len_full;
  logic                 mode_pads;
  logic                 pad_on;
  logic                 pad_final;
  logic                 out_free;
  logic [LFSR_W-1:0]    lfsr_next;
  logic [BYTE_W-1:0]    pad_byte;
  logic [BYTE_W-1:0]    pad_len_byte;

  assign bs_eff     = (bsize_q > BS_MAX) ? BS_MAX : bsize_q;
  assign count_full = BSIZE_W'(pos_q) + BSIZE_W'(1);
  // a zero block size also lands here, so the position stays at zero
  assign count      = (count_full >= bs_eff) ? '0 : count_full;

  always_comb begin
    unique case (mode_q)
      MODE_PKCS7, MODE_ISO7816, MODE_ISO10126, MODE_ANSI923, MODE_ZERO: mode_pads = 1'b1;
      default: mode_pads = 1'b0;
    endcase
  end

  assign pad_on       = is_last_i && (count != '0) && mode_pads;
  assign pad_len_full = bs_eff - count;
  assign pad_final    = (BSIZE_W'(pad_idx_q) + BSIZE_W'(1)) == BSIZE_W'(pad_len_q);
  assign out_free     = !out_valid_q || out_ready_i;
  assign lfsr_next    = lfsr_step8(lfsr_q);
  assign pad_len_byte = BYTE_W'(pad_len_q);

  always_comb begin
    unique case (mode_q)
      MODE_PKCS7:    pad_byte = pad_len_byte;
      MODE_ISO7816:  pad_byte = (pad_idx_q == '0) ? ISO_MARK : '0;
      MODE_ISO10126: pad_byte = pad_final ? pad_len_byte : lfsr_next[BYTE_W-1:0];
      MODE_ANSI923:  pad_byte = pad_final ? pad_len_byte : '0;
      default:       pad_byte = '0;
    endcase
  end

  assign sts_o.pad_on    = pad_on;
  assign sts_o.pad_final = pad_final;
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      bsize_q     <= BSIZE_RESET;
      pos_q       <= '0;
      lfsr_q      <= LFSR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PADDING_MODE: mode_q  <= pad_mode_e'(cfg_data_i[MODE_W-1:0]);
          CFG_BLOCK_SIZE:   bsize_q <= cfg_data_i[BSIZE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load_msg) begin
        pos_q <= is_last_i ? '0 : count[POS_W-1:0];
      end
      // the lfsr only moves on random pad bytes
      if (cmd_i.load_pad && (mode_q == MODE_ISO10126) && !pad_final) begin
        lfsr_q <= lfsr_next;
      end
      if (cmd_i.load_msg || cmd_i.load_pad) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_msg) begin
      out_byte_q <= data_byte_i;
      is_pad_q   <= 1'b0;
      eom_q      <= is_last_i && !pad_on;
      pad_len_q  <= pad_len_full[POS_W-1:0];
      pad_idx_q  <= '0;
    end else if (cmd_i.load_pad) begin
      out_byte_q <= pad_byte;
      is_pad_q   <= 1'b1;
      eom_q      <= pad_final;
      pad_idx_q  <= pad_idx_q + POS_W'(1);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign is_pad_o         = is_pad_q;
  assign end_of_message_o = eom_q;

endmodule

[rtl/core/bcsp_ctrl.sv]
// padder controller: message pass-through and pad emission sequencing
module bcsp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcsp_pkg::dp_sts_t   sts_i,
  output bcsp_pkg::ctl_cmd_t  cmd_o
);
  import bcsp_pkg::*;

  typedef enum logic {
    ST_MSG,
    ST_PAD
  } state_e;

  state_e state_q;
  logic   load_msg;
  logic   load_pad;

  assign in_ready_o = (state_q == ST_MSG) && sts_i.out_free;
  assign load_msg   = in_valid_i && in_ready_o;
  assign load_pad   = (state_q == ST_PAD) && sts_i.out_free;

  assign cmd_o.load_msg = load_msg;
  assign cmd_o.load_pad = load_pad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_MSG;
    end else begin
      unique case (state_q)
        ST_MSG: if (load_msg && sts_i.pad_on) state_q <= ST_PAD;
        ST_PAD: if (load_pad && sts_i.pad_final) state_q <= ST_MSG;
        default: state_q <= ST_MSG;
      endcase
    end
  end

endmodule

[rtl/core/block_cipher_stream_padder.sv]
// Block cipher stream padder, top level.
// in_i takes message bytes with is_last on the final byte; out_o gives each
// message byte followed, after a last byte that leaves a partial block, by pad
// bytes up to the block boundary, with is_pad set and end_of_message on the
// final byte. Aligned messages, mode none and unknown modes get no pad.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 padding_mode,
// 1 block_size); write only while no message byte is in flight.
// An accepted byte is registered and shows on out_o in the cycle after it is accepted.
// Throughput: one output byte per cycle while out_o does not stall, through a
// single output register; a last byte that needs pad bytes holds off the
// input while the pad counter runs.
// When out_o stalls, the output register holds and in_i.ready drops until
// the held byte is taken.
// Reset clears the block position and output valid, loads the lfsr with
// 0xACE1, mode none and block size 16.
module block_cipher_stream_padder #(
  parameter int unsigned MAX_BLOCK_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bcsp_pkg::CFG_W-1:0]     cfg_data_i,
  bcsp_in_if.sink                       in_i,
  bcsp_out_if.source                    out_o
);
  import bcsp_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bcsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bcsp_datapath #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .data_byte_i      (in_i.data_byte),
    .is_last_i        (in_i.is_last),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_byte_o       (out_o.out_byte),
    .is_pad_o         (out_o.is_pad),
    .end_of_message_o (out_o.end_of_message)
  );

endmodule

[rtl/core/bcsp_checker.sv]
// port-level checks for the block cipher stream padder, bound to the top level
module bcsp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [bcsp_pkg::BYTE_W-1:0] out_byte_i,
  input logic                       is_pad_i,
  input logic                       end_of_message_i
);

  // an accepted item shows on the output in the next cycle
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted item not presented on output");

  // the first byte out after an accept is the message byte itself
  a_msg_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !is_pad_i)
    else $error("pad byte ahead of message byte");

  // input is held off while a pad run is unfinished
  a_pad_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && is_pad_i && !end_of_message_i) |-> !in_ready_i)
    else $error("input accepted during pad run");

  // a pad byte that is not the last one is followed by another pad byte
  a_pad_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && is_pad_i && !end_of_message_i)
      |=> (out_valid_i && is_pad_i))
    else $error("pad run cut short");

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_byte_i)))
    else $error("stalled output changed");

endmodule

bind block_cipher_stream_padder bcsp_checker u_bcsp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_byte_i       (out_o.out_byte),
  .is_pad_i         (out_o.is_pad),
  .end_of_message_i (out_o.end_of_message)
);

[tb/sv/tb_block_cipher_stream_padder.sv]
// self-checking testbench for the block cipher stream padder with its own padding predictor
module tb_block_cipher_stream_padder;
  timeunit 1ns;
  timeprecision 1ps;

  import bcsp_pkg::*;

  localparam int unsigned MAX_BYTES  = 64;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned RAND_ITEMS = 300;

  // mode codes that the block treats as no padding
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;
  } msg_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_pad;
    logic              end_of_message;
  } pad_out_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bcsp_in_if  in_if ();
  bcsp_out_if out_if ();

  block_cipher_stream_padder #(
    .MAX_BLOCK_BYTES(MAX_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  msg_item_t msg_q[$];
  pad_out_t  padded_q[$];

  int unsigned n_sent;
  int unsigned n_taken;
  int unsigned n_fail;
  int unsigned hold_req;

  // predictor state and configuration
  logic [MODE_W-1:0]  pad_mode;
  logic [BSIZE_W-1:0] blk_size;
  logic [5:0]         blk_pos;
  logic [LFSR_W-1:0]  prng;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // eight shifts of the fibonacci register, low byte is the pad value
  function automatic logic [BYTE_W-1:0] prng_next();
    logic [LFSR_W-1:0] s;
    logic              fb;
    s = prng;
    for (int k = 0; k < 8; k++) begin
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      s  = (s >> 1) | (LFSR_W'(fb) << (LFSR_W - 1));
    end
    prng = s;
    return s[BYTE_W-1:0];
  endfunction

  task automatic pad_predict(input logic [BYTE_W-1:0] data, input logic last);
    int          bs;
    int          cnt;
    int          npad;
    logic        pad_on;
    logic        last_pad;
    pad_out_t    r;
    logic [BYTE_W-1:0] b;
    bs = (blk_size > MAX_BYTES) ? MAX_BYTES : int'(blk_size);
    if (bs == 0) begin
      cnt = 0;
    end else begin
      cnt = int'(blk_pos) + 1;
      if (cnt >= bs) cnt = 0;
    end
    pad_on = last && bs != 0 && cnt != 0 && pad_mode >= MODE_PKCS7 && pad_mode <= MODE_ZERO;
    npad   = pad_on ? bs - cnt : 0;
    r.out_byte       = data;
    r.is_pad         = 1'b0;
    r.end_of_message = last && !pad_on;
    padded_q.push_back(r);
    for (int i = 0; i < npad; i++) begin
      last_pad = (i + 1 == npad);
      case (pad_mode)
        MODE_PKCS7:    b = BYTE_W'(npad);
        MODE_ISO7816:  b = (i == 0) ? ISO_MARK : '0;
        MODE_ISO10126: b = last_pad ? BYTE_W'(npad) : prng_next();
        MODE_ANSI923:  b = last_pad ? BYTE_W'(npad) : '0;
        default:       b = '0;
      endcase
      r.out_byte       = b;
      r.is_pad         = 1'b1;
      r.end_of_message = last_pad;
      padded_q.push_back(r);
    end
    blk_pos = last ? '0 : 6'(cnt);
  endtask

  // sender: pops pending items, random gaps between them
  int unsigned in_gap;
  int unsigned in_calm;
  always @(posedge clk_i or negedge rst_ni) begin : msg_driver
    msg_item_t it;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= '0;
      in_if.is_last   <= 1'b0;
      in_gap  = 0;
      in_calm = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (msg_q.size() > 0) begin
        it = msg_q.pop_front();
        in_if.data_byte <= it.data_byte;
        in_if.is_last   <= it.is_last;
        in_if.valid     <= 1'b1;
        if (in_calm > 0) begin
          in_calm--;
        end else begin
          in_gap = idle_len();
          if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 100);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  int unsigned out_stall;
  int unsigned out_calm;
  int unsigned hold_served;
  always @(posedge clk_i or negedge rst_ni) begin : rdy_driver
    logic rdy;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall   = 0;
      out_calm    = 0;
      hold_served = 0;
    end else begin
      if (hold_served != hold_req) begin
        hold_served++;
        out_stall = LONG_HOLD;
      end
      if (out_stall > 0) begin
        out_stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          out_stall = idle_len();
          if ($urandom_range(0, 49) == 0) out_calm = $urandom_range(20, 100);
        end
      end
      out_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      pad_predict(in_if.data_byte, in_if.is_last);
      n_taken++;
    end
  end

  always @(posedge clk_i) begin : out_check
    pad_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (padded_q.size() == 0) begin
        $error("unexpected output item: out_byte %02h is_pad %0b end_of_message %0b",
               out_if.out_byte, out_if.is_pad, out_if.end_of_message);
        n_fail++;
      end else begin
        want = padded_q.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_if.out_byte);
          n_fail++;
        end
        if (out_if.is_pad !== want.is_pad) begin
          $error("is_pad: expected %0b, got %0b", want.is_pad, out_if.is_pad);
          n_fail++;
        end
        if (out_if.end_of_message !== want.end_of_message) begin
          $error("end_of_message: expected %0b, got %0b", want.end_of_message,
                 out_if.end_of_message);
          n_fail++;
        end
      end
    end
  end

  task automatic send(input logic [BYTE_W-1:0] data, input logic last);
    msg_item_t it;
    it.data_byte = data;
    it.is_last   = last;
    msg_q.push_back(it);
    n_sent++;
  endtask

  task automatic send_msg(input int len, input logic closed);
    for (int i = 0; i < len; i++) send(BYTE_W'($urandom_range(0, 255)), closed && i == len - 1);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (n_taken != n_sent || padded_q.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PADDING_MODE) pad_mode = val[MODE_W-1:0];
    else blk_size = val[BSIZE_W-1:0];
  endtask

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned rnd_items;
    int          per;
    int          len;
    int          lim;
    int          eff;
    int          phase;
    int          guard;
    logic [MODE_W-1:0]  m;
    logic [BSIZE_W-1:0] b;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_PADDING_MODE;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.is_last   = 1'b0;
    out_if.ready    = 1'b0;
    n_sent   = 0;
    n_taken  = 0;
    n_fail   = 0;
    hold_req = 0;
    pad_mode = MODE_NONE;
    blk_size = BSIZE_RESET;
    blk_pos  = '0;
    prng     = LFSR_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // block size left at its reset value
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_PKCS7));
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    set_reg(CFG_BLOCK_SIZE, 7'd8);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ISO7816));
    send(8'hA5, 1'b1);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ISO10126));
    send(8'h3C, 1'b1);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_NONE));
    send(8'h81, 1'b1);

    // one pad byte in every padding mode
    set_reg(CFG_BLOCK_SIZE, 7'd2);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_PKCS7));
    send(8'h5A, 1'b1);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ISO7816));
    send(8'h01, 1'b1);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ISO10126));
    send(8'h02, 1'b1);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ANSI923));
    send(8'h04, 1'b1);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ZERO));
    send(8'h08, 1'b1);

    // aligned messages, block size one and zero
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_PKCS7));
    send(8'h11, 1'b0);
    send(8'h22, 1'b1);
    set_reg(CFG_BLOCK_SIZE, 7'd1);
    send(8'h33, 1'b1);
    set_reg(CFG_BLOCK_SIZE, 7'd0);
    send(8'h44, 1'b0);
    send(8'h55, 1'b1);

    // largest block, then a size above the maximum
    set_reg(CFG_BLOCK_SIZE, 7'd64);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ZERO));
    send(8'h66, 1'b1);
    set_reg(CFG_BLOCK_SIZE, 7'd127);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_ANSI923));
    send(8'h77, 1'b1);

    // unknown modes pad nothing
    set_reg(CFG_BLOCK_SIZE, 7'd8);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_RSVD6));
    send(8'h88, 1'b1);
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_RSVD7));
    send(8'h99, 1'b1);

    // block size shrinks in the middle of a message
    set_reg(CFG_PADDING_MODE, CFG_W'(MODE_PKCS7));
    send_msg(4, 1'b0);
    set_reg(CFG_BLOCK_SIZE, 7'd3);
    send(8'hCC, 1'b1);
    set_reg(CFG_BLOCK_SIZE, 7'd8);
    send(8'hBB, 1'b0);
    set_reg(CFG_BLOCK_SIZE, 7'd4);
    send(8'hDD, 1'b1);

    rnd_items = 0;
    phase     = 0;
    while (rnd_items < RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        m = MODE_W'($urandom_range(MODE_PKCS7, MODE_ZERO));
      end else begin
        case ($urandom_range(0, 2))
          0:       m = MODE_NONE;
          1:       m = MODE_RSVD6;
          default: m = MODE_RSVD7;
        endcase
      end
      case ($urandom_range(0, 19))
        0:       b = 7'd0;
        1, 2:    b = 7'd64;
        3:       b = BSIZE_W'($urandom_range(65, 127));
        default: b = BSIZE_W'($urandom_range(1, 16));
      endcase
      set_reg(CFG_PADDING_MODE, CFG_W'(m));
      set_reg(CFG_BLOCK_SIZE, b);
      eff = (b == 0) ? 8 : ((b > MAX_BYTES) ? MAX_BYTES : int'(b));
      lim = (2 * eff < 4) ? 4 : 2 * eff;
      per = 0;
      while (per < 40) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray item with a random last flag
          send(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          per++;
        end else begin
          len = $urandom_range(1, lim);
          send_msg(len, 1'b1);
          per += len;
        end
      end
      // leave a message open so the next block size lands mid-message
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, lim);
        send_msg(len, 1'b0);
        per += len;
      end
      // stall the output while the input queue is still full
      if (phase == 1 || $urandom_range(0, 7) == 0) hold_req++;
      rnd_items += per;
      phase++;
    end

    guard = 0;
    while ((n_taken != n_sent || padded_q.size() != 0) && guard < 10_000_000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (n_taken != n_sent || padded_q.size() != 0) begin
      $error("%0d output items never arrived", padded_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
